[rtl/chained_hash_table_macros.svh]
// Assertion macros shared by the chained hash table RTL.
`ifndef CHAINED_HASH_TABLE_MACROS_SVH
`define CHAINED_HASH_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check prop on every clock edge outside reset.
`define CHT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that cond never holds outside reset.
`define CHT_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst, prop, msg)
`define CHT_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/cht_pkg.sv]
// Types and constants of the chained hash table.
package cht_pkg;

  localparam int POOL_ENTRIES = 256;
  localparam int DATA_BITS    = 32;
  localparam int BUCKETS      = 256;
  localparam int HASH_BITS    = 32;
  localparam int WORD_BITS    = 32;

  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int PTR_W = $clog2(POOL_ENTRIES + 1);
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int ENT_W = HASH_BITS + DATA_BITS;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_DONE
  } state_t;

endpackage

[rtl/cht_if.sv]
// Request and response channel interfaces of the chained hash table.
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key_hash;
  logic [31:0] payload;

  modport source (output valid, output cmd, output key_hash, output payload, input ready);
  modport sink (input valid, input cmd, input key_hash, input payload, output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_data;

  modport source (output valid, output status, output found_data, input ready);
  modport sink (input valid, input status, input found_data, output ready);
endinterface

[rtl/cht_ram.sv]
// Generic simple dual-port RAM with registered read.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/chained_hash_table.sv]
// Hash table with separate chaining over a fixed pool, walked one entry per cycle.
// An accepted request moves IDLE -> HEAD (bucket head read) -> WALK (chain entries read;
// skipped for an empty bucket, a full pool or an unknown command) -> DONE (response load).
// Requests are accepted only in IDLE, so a walk or a stalled response holds off the next one.
// Reset: synchronous; clears the sequencer, used count, bucket valid bits and response valid.
// Pool entries are undefined until written, so no clearing pass runs after reset.
`include "chained_hash_table_macros.svh"

module chained_hash_table (
  input  logic      clk,
  input  logic      rst,
  cht_req_if.sink   req,
  cht_rsp_if.source rsp
);

  cht_pkg::state_t state, state_next;

  logic [1:0]                    cmd;
  logic [cht_pkg::HASH_BITS-1:0] hash;
  logic [cht_pkg::DATA_BITS-1:0] data;
  logic [cht_pkg::PTR_W-1:0]     cur, cur_next;
  logic [cht_pkg::PTR_W-1:0]     prev, prev_next;
  logic [cht_pkg::PTR_W-1:0]     slot, slot_next;
  logic [cht_pkg::PTR_W-1:0]     used, used_next;
  logic [cht_pkg::BUCKETS-1:0]   head_valid;
  logic                          set_valid;

  cht_pkg::status_t              res_status, res_status_next;
  logic [cht_pkg::WORD_BITS-1:0] res_data, res_data_next;

  logic                          out_valid;
  cht_pkg::status_t              out_status;
  logic [cht_pkg::WORD_BITS-1:0] out_data;
  logic                          out_free;

  logic                      head_we;
  logic [cht_pkg::BKT_W-1:0] head_waddr;
  logic [cht_pkg::PTR_W-1:0] head_wdata;
  logic [cht_pkg::BKT_W-1:0] head_raddr;
  logic [cht_pkg::PTR_W-1:0] head_rd;

  logic                      ent_we;
  logic [cht_pkg::ENT_W-1:0] ent_wdata;
  logic [cht_pkg::ENT_W-1:0] ent_rd;

  logic                      next_we;
  logic [cht_pkg::IDX_W-1:0] next_waddr;
  logic [cht_pkg::PTR_W-1:0] next_wdata;
  logic [cht_pkg::PTR_W-1:0] next_rd;

  logic [cht_pkg::IDX_W-1:0] rd_idx;

  logic [cht_pkg::BKT_W-1:0]     bucket;
  logic [cht_pkg::PTR_W-1:0]     head;
  logic                          head_nil;
  logic                          next_nil;
  logic                          match;
  logic                          pool_full;
  logic                          is_insert;
  logic                          is_lookup;
  logic                          accept;

  cht_ram #(.WIDTH(cht_pkg::PTR_W), .DEPTH(cht_pkg::BUCKETS)) u_head_ram (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_addr (head_raddr),
    .rd_data (head_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::ENT_W), .DEPTH(cht_pkg::POOL_ENTRIES)) u_ent_ram (
    .clk     (clk),
    .wr_en   (ent_we),
    .wr_addr (used[cht_pkg::IDX_W-1:0]),
    .wr_data (ent_wdata),
    .rd_addr (rd_idx),
    .rd_data (ent_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::PTR_W), .DEPTH(cht_pkg::POOL_ENTRIES)) u_next_ram (
    .clk     (clk),
    .wr_en   (next_we),
    .wr_addr (next_waddr),
    .wr_data (next_wdata),
    .rd_addr (rd_idx),
    .rd_data (next_rd)
  );

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == cht_pkg::S_IDLE);
  assign out_free   = !out_valid || rsp.ready;
  assign bucket     = hash[cht_pkg::BKT_W-1:0];
  assign head_raddr = req.key_hash[cht_pkg::BKT_W-1:0];
  assign head       = head_valid[bucket] ? head_rd : cht_pkg::NIL;
  assign head_nil   = (head == cht_pkg::NIL);
  assign next_nil   = (next_rd == cht_pkg::NIL);
  assign match      = (ent_rd[cht_pkg::ENT_W-1 -: cht_pkg::HASH_BITS] == hash);
  assign pool_full  = (used == cht_pkg::NIL);
  assign is_insert  = (cmd == cht_pkg::CMD_INSERT);
  assign is_lookup  = (cmd == cht_pkg::CMD_FIND) || (cmd == cht_pkg::CMD_DELETE);

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found_data = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      cht_pkg::S_IDLE: begin
        if (accept) begin
          state_next = cht_pkg::S_HEAD;
        end
      end
      cht_pkg::S_HEAD: begin
        if ((is_insert && !pool_full && !head_nil) || (is_lookup && !head_nil)) begin
          state_next = cht_pkg::S_WALK;
        end else begin
          state_next = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_WALK: begin
        if (next_nil || (!is_insert && match)) begin
          state_next = cht_pkg::S_DONE;
        end
      end
      cht_pkg::S_DONE: begin
        if (out_free) begin
          state_next = cht_pkg::S_IDLE;
        end
      end
      default: state_next = cht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_we         = 1'b0;
    head_waddr      = bucket;
    head_wdata      = used;
    ent_we          = 1'b0;
    ent_wdata       = {hash, data};
    next_we         = 1'b0;
    next_waddr      = used[cht_pkg::IDX_W-1:0];
    next_wdata      = cht_pkg::NIL;
    rd_idx          = '0;
    cur_next        = cur;
    prev_next       = prev;
    slot_next       = slot;
    used_next       = used;
    set_valid       = 1'b0;
    res_status_next = res_status;
    res_data_next   = res_data;
    unique case (state)
      cht_pkg::S_IDLE: ;
      cht_pkg::S_HEAD: begin
        res_status_next = cht_pkg::ST_NOT_FOUND;
        res_data_next   = '0;
        prev_next       = cht_pkg::NIL;
        cur_next        = head;
        rd_idx          = head[cht_pkg::IDX_W-1:0];
        unique case (cmd) inside
          cht_pkg::CMD_INSERT: begin
            if (pool_full) begin
              res_status_next = cht_pkg::ST_FULL;
            end else begin
              res_status_next = cht_pkg::ST_OK;
              ent_we          = 1'b1;
              next_we         = 1'b1;
              used_next       = used + cht_pkg::PTR_W'(1);
              slot_next       = used;
              if (head_nil) begin
                head_we   = 1'b1;
                set_valid = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      cht_pkg::S_WALK: begin
        if (is_insert) begin
          if (next_nil) begin
            next_we    = 1'b1;
            next_waddr = cur[cht_pkg::IDX_W-1:0];
            next_wdata = slot;
          end else begin
            cur_next = next_rd;
            rd_idx   = next_rd[cht_pkg::IDX_W-1:0];
          end
        end else if (match) begin
          res_status_next = cht_pkg::ST_OK;
          res_data_next   = cht_pkg::WORD_BITS'(ent_rd[cht_pkg::DATA_BITS-1:0]);
          if (cmd == cht_pkg::CMD_DELETE) begin
            if (prev == cht_pkg::NIL) begin
              head_we    = 1'b1;
              head_wdata = next_rd;
            end else begin
              next_we    = 1'b1;
              next_waddr = prev[cht_pkg::IDX_W-1:0];
              next_wdata = next_rd;
            end
          end
        end else if (!next_nil) begin
          prev_next = cur;
          cur_next  = next_rd;
          rd_idx    = next_rd[cht_pkg::IDX_W-1:0];
        end
      end
      cht_pkg::S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cht_pkg::S_IDLE;
      used       <= '0;
      head_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (set_valid) begin
        head_valid[bucket] <= 1'b1;
      end
      if (state == cht_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= req.cmd;
      hash <= req.key_hash;
      data <= cht_pkg::DATA_BITS'(req.payload);
    end
    cur        <= cur_next;
    prev       <= prev_next;
    slot       <= slot_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    if (state == cht_pkg::S_DONE && out_free) begin
      out_status <= res_status;
      out_data   <= res_data;
    end
  end

  `CHT_ASSERT(a_used_bound, clk, rst, (used <= cht_pkg::NIL), "used count beyond pool size")
  `CHT_ASSERT(a_used_step, clk, rst, (!$stable(used) |-> $past(state == cht_pkg::S_HEAD && cmd == cht_pkg::CMD_INSERT)), "used count moved outside an insert")
  `CHT_ASSERT_NEVER(a_walk_nil, clk, rst, (state == cht_pkg::S_WALK && cur == cht_pkg::NIL), "chain walk on a null link")
  `CHT_ASSERT(a_rsp_load, clk, rst, ($rose(rsp.valid) |-> $past(state == cht_pkg::S_DONE)), "response loaded outside done state")
  `CHT_ASSERT(a_accept_seq, clk, rst, (accept |=> state == cht_pkg::S_HEAD), "accepted beat did not start a head read")

endmodule
